// ===== design/acsa_pkg.sv =====
package acsa_pkg;

   // Field widths of one input beat and one result beat.
   localparam int SAMPLE_W  = 10;
   localparam int CHANNEL_W = 3;
   localparam int MUX_W     = 4;
   localparam int AVERAGE_W = 10;

   // Internal state widths.
   localparam int ACC_W   = 16;
   localparam int COUNT_W = 7;

   // Configuration register widths and port geometry.
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int CHANNEL_COUNT_W = 4;
   localparam int SHIFT_W         = 3;
   localparam int MUX_TABLE_W     = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_SHIFT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MUX_TABLE     = 2'd2;

   // Register reset values.
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd1;
   localparam logic [SHIFT_W-1:0]         SAMPLE_SHIFT_RESET  = 3'd2;
   localparam logic [MUX_TABLE_W-1:0]     MUX_TABLE_RESET     = 32'd0;

   // Largest shift honoured; a larger code is clamped to it.
   localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd6;

   // Request codes.
   localparam logic REQ_CONVERSION = 1'b0;
   localparam logic REQ_READ       = 1'b1;

   typedef struct packed {
      logic [CHANNEL_COUNT_W-1:0] channel_count;
      logic [SHIFT_W-1:0]         sample_shift;
      logic [MUX_TABLE_W-1:0]     mux_table;
   } config_type;

   typedef struct packed {
      logic [AVERAGE_W-1:0] read_value;
      logic [MUX_W-1:0]     mux_code;
      logic [CHANNEL_W-1:0] active_channel;
      logic                 average_stored;
   } result_type;

endpackage

// ===== design/acsa_if.sv =====
// Request channel: one conversion result or one average read per beat.
interface acsa_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [acsa_pkg::SAMPLE_W-1:0]   sample;
   logic [acsa_pkg::CHANNEL_W-1:0]  read_channel;

   modport source (output valid, output req_type, output sample, output read_channel,
                   input ready);
   modport sink   (input valid, input req_type, input sample, input read_channel,
                   output ready);
endinterface

// Response channel: one result per request beat.
interface acsa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [acsa_pkg::AVERAGE_W-1:0]  read_value;
   logic [acsa_pkg::MUX_W-1:0]      mux_code;
   logic [acsa_pkg::CHANNEL_W-1:0]  active_channel;
   logic                            average_stored;

   modport source (output valid, output read_value, output mux_code,
                   output active_channel, output average_stored, input ready);
   modport sink   (input valid, input read_value, input mux_code,
                   input active_channel, input average_stored, output ready);
endinterface

// ===== design/acsa_scan_core.sv =====
module acsa_scan_core #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            req_type,
   input  logic [acsa_pkg::SAMPLE_W-1:0]   sample,
   input  logic [acsa_pkg::CHANNEL_W-1:0]  read_channel,
   input  acsa_pkg::config_type            cfg,
   output acsa_pkg::result_type            result
);

   // Only eight scan positions are addressable, so at most eight slots exist.
   localparam int SLOTS  = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [acsa_pkg::CHANNEL_W:0]       SLOT_LIMIT = (acsa_pkg::CHANNEL_W + 1)'(SLOTS);
   localparam logic [acsa_pkg::CHANNEL_COUNT_W:0] MAX_COUNT  =
      (acsa_pkg::CHANNEL_COUNT_W + 1)'(NUM_CHANNELS);

   logic [acsa_pkg::ACC_W-1:0]     accumulator_ff, accumulator_in;
   logic [acsa_pkg::COUNT_W-1:0]   sample_count_ff, sample_count_in;
   logic [acsa_pkg::CHANNEL_W-1:0] channel_index_ff, channel_index_in;
   logic [acsa_pkg::AVERAGE_W-1:0] average_ff [SLOTS];

   logic [acsa_pkg::SHIFT_W-1:0]         shift_eff;
   logic [acsa_pkg::COUNT_W-1:0]         count_limit;
   logic [acsa_pkg::CHANNEL_COUNT_W:0]   count_eff;
   logic [acsa_pkg::CHANNEL_COUNT_W:0]   index_next;
   logic [acsa_pkg::AVERAGE_W-1:0]       new_average;
   logic                                 store_average;
   logic                                 write_slot;
   logic                                 read_in_range;

   // Clamp the configuration to the supported ranges.
   always_comb begin
      shift_eff = (cfg.sample_shift > acsa_pkg::MAX_SHIFT) ? acsa_pkg::MAX_SHIFT
                                                          : cfg.sample_shift;
      count_limit = acsa_pkg::COUNT_W'(1) << shift_eff;
      if (cfg.channel_count == '0) begin
         count_eff = (acsa_pkg::CHANNEL_COUNT_W + 1)'(1);
      end else if ({1'b0, cfg.channel_count} > MAX_COUNT) begin
         count_eff = MAX_COUNT;
      end else begin
         count_eff = {1'b0, cfg.channel_count};
      end
   end

   // Accumulate, or close the channel's average and move the scan on.
   always_comb begin
      accumulator_in   = accumulator_ff;
      sample_count_in  = sample_count_ff;
      channel_index_in = channel_index_ff;
      store_average    = 1'b0;
      new_average      = acsa_pkg::AVERAGE_W'(accumulator_ff >> shift_eff);
      index_next       = (acsa_pkg::CHANNEL_COUNT_W + 1)'(channel_index_ff) + 1'b1;
      if (req_type == acsa_pkg::REQ_CONVERSION) begin
         if (sample_count_ff < count_limit) begin
            sample_count_in = sample_count_ff + 1'b1;
            accumulator_in  = accumulator_ff + acsa_pkg::ACC_W'(sample);
         end else begin
            store_average   = 1'b1;
            accumulator_in  = '0;
            sample_count_in = '0;
            channel_index_in = (index_next >= count_eff) ? '0
                               : index_next[acsa_pkg::CHANNEL_W-1:0];
         end
      end
   end

   assign write_slot    = store_average && ({1'b0, channel_index_ff} < SLOT_LIMIT);
   assign read_in_range = {1'b0, read_channel} < SLOT_LIMIT;

   // Scan state advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         accumulator_ff   <= '0;
         sample_count_ff  <= '0;
         channel_index_ff <= '0;
      end else if (accept) begin
         accumulator_ff   <= accumulator_in;
         sample_count_ff  <= sample_count_in;
         channel_index_ff <= channel_index_in;
      end
   end

   // Per-channel averages, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            average_ff[i] <= '0;
         end
      end else if (accept && write_slot) begin
         average_ff[channel_index_ff[SLOT_W-1:0]] <= new_average;
      end
   end

   // Result of the beat, as seen after its state update.
   always_comb begin
      result.read_value = '0;
      if (req_type == acsa_pkg::REQ_READ && read_in_range) begin
         result.read_value = average_ff[read_channel[SLOT_W-1:0]];
      end
      result.active_channel = channel_index_in;
      result.mux_code       = cfg.mux_table[{channel_index_in, 2'b00} +: acsa_pkg::MUX_W];
      result.average_stored = store_average;
   end

endmodule

// ===== design/adc_channel_scan_averager.sv =====
// ADC channel scan averager. Each conversion beat either adds its sample to the running
// sum of the active channel or, once 2^s samples are in (s = sample_shift, at most 6), is
// dropped while the sum shifted down by s is stored as that channel's average and the scan
// moves to the next channel (back to channel 0 after channel_count-1); each response
// reports the active channel and its mux code. A read beat returns a channel's stored
// average. One request is taken every clock unless stalled: the state update is a single
// add and compare, and the response sits in one output register that is refilled in the
// cycle it is taken, so a response appears in the cycle after its request. Configuration
// writes are taken at any time but should be made only while no request is in flight.
module adc_channel_scan_averager #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   acsa_req_if.sink                              req_chan,
   acsa_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [acsa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [acsa_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   acsa_pkg::config_type cfg_ff;
   acsa_pkg::result_type result;
   acsa_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff;
   logic                 req_accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= acsa_pkg::CHANNEL_COUNT_RESET;
         cfg_ff.sample_shift  <= acsa_pkg::SAMPLE_SHIFT_RESET;
         cfg_ff.mux_table     <= acsa_pkg::MUX_TABLE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            acsa_pkg::CSR_CHANNEL_COUNT: begin
               cfg_ff.channel_count <= csr_write_data[acsa_pkg::CHANNEL_COUNT_W-1:0];
            end
            acsa_pkg::CSR_SAMPLE_SHIFT: begin
               cfg_ff.sample_shift <= csr_write_data[acsa_pkg::SHIFT_W-1:0];
            end
            acsa_pkg::CSR_MUX_TABLE: begin
               cfg_ff.mux_table <= csr_write_data[acsa_pkg::MUX_TABLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A new beat is taken whenever the output register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   acsa_scan_core #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_scan_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req_type     (req_chan.req_type),
      .sample       (req_chan.sample),
      .read_channel (req_chan.read_channel),
      .cfg          (cfg_ff),
      .result       (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_value     = rsp_data_ff.read_value;
   assign rsp_chan.mux_code       = rsp_data_ff.mux_code;
   assign rsp_chan.active_channel = rsp_data_ff.active_channel;
   assign rsp_chan.average_stored = rsp_data_ff.average_stored;

endmodule

// ===== design/acsa_checker.sv =====
module acsa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [acsa_pkg::AVERAGE_W-1:0]  rsp_read_value,
   input logic [acsa_pkg::MUX_W-1:0]      rsp_mux_code,
   input logic [acsa_pkg::CHANNEL_W-1:0]  rsp_active_channel,
   input logic                            rsp_average_stored
);

   // Every accepted request produces a response beat in the next cycle.
   a_request_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   // Storing an average happens only on conversion beats, which read back zero.
   a_store_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_average_stored |-> rsp_read_value == '0)
      else $error("average stored on a beat carrying read data");

   // A stalled response stays offered.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_value) && $stable(rsp_mux_code)
         && $stable(rsp_active_channel) && $stable(rsp_average_stored))
      else $error("response payload changed while stalled");

endmodule

bind adc_channel_scan_averager acsa_checker u_acsa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_read_value     (rsp_chan.read_value),
   .rsp_mux_code       (rsp_chan.mux_code),
   .rsp_active_channel (rsp_chan.active_channel),
   .rsp_average_stored (rsp_chan.average_stored)
);
